// ===== hw/rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 17;
   localparam int CAP_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic cmp_en;
      logic shift_en;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/lkv_cell.sv =====
// One cache entry of the recency chain: key compare and shift from the younger neighbour.
module lkv_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  lkv_pkg::cell_ctrl_type    ctrl,
   input  logic [lkv_pkg::KEY_W-1:0] cmp_key,
   input  lkv_pkg::entry_type        left_entry,
   output lkv_pkg::entry_type        entry,
   output logic                      match
);

   logic                        valid_ff, valid_in;
   logic [lkv_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lkv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        match_ff, match_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (ctrl.shift_en) begin
         valid_in = left_entry.valid;
         key_in   = left_entry.key;
         value_in = left_entry.value;
      end
      if (ctrl.cmp_en) begin
         match_in = valid_ff && (key_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = match_ff;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: recency chain of entry cells and request control.
// At the accepting edge of a request the key is compared against every cell at once, and
// in the following cycle the chain shifts by one place to bring the hit or new entry to the
// head (head is most recent, the last valid cell is least recent).
// The result strobe rsp_valid is high for one cycle right after that update and cannot be
// held off; busy is high during the update cycle only; a request is not taken while
// busy but can be taken in the cycle that shows the previous result. No clearing pass
// after reset is needed. Capacity writes are taken at any time via csr_valid (csr_ready is
// always high) but must only be made while the block is idle.
module lru_key_value_cache #(
   parameter int ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [lkv_pkg::KEY_W-1:0]   req_key,
   input  logic [lkv_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [lkv_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                        rsp_evicted,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]   csr_capacity
);

   localparam int FW  = $clog2(ENTRIES + 1);
   localparam int CW  = (FW > lkv_pkg::CAP_W) ? FW : lkv_pkg::CAP_W;
   localparam int LOG = $clog2(ENTRIES);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic                        state_ff, state_in;
   logic                        type_ff, type_in;
   logic [lkv_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lkv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [lkv_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [lkv_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_evict_ff, rsp_evict_in;

   logic                        accept;
   logic                        in_update;
   logic [ENTRIES-1:0]          match_vec;
   logic [ENTRIES-1:0]          valid_vec;
   logic [ENTRIES-1:0]          lvl [0:LOG];
   logic [ENTRIES-1:0]          shift_mask;
   logic                        hit;
   logic [lkv_pkg::VALUE_W-1:0] hit_value;
   logic [CW-1:0]               cap_ext, eff_cap;
   logic                        full;
   logic                        do_evict;
   logic                        do_fill;
   logic                        do_shift;
   logic [FW:0]                 miss_limit;
   lkv_pkg::entry_type          head_entry;
   lkv_pkg::entry_type          entries [ENTRIES];
   lkv_pkg::cell_ctrl_type      ctrls [ENTRIES];
   logic [ENTRIES-1:0]          lkv_match;

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_update = (state_ff == ST_UPDATE);

   // Matches at or before each position, log-depth prefix OR
   always_comb begin
      lvl[0] = match_vec;
      for (int l = 0; l < LOG; l++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (i >= (1 << l)) begin
               lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
            end else begin
               lvl[l+1][i] = lvl[l][i];
            end
         end
      end
   end

   assign hit = lvl[LOG][ENTRIES-1];

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | (match_vec[i] ? entries[i].value : '0);
      end
   end

   always_comb begin
      cap_ext = CW'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full       = CW'(fill_ff) >= eff_cap;
   assign do_evict   = in_update && !hit && (type_ff == lkv_pkg::REQ_PUT) && full;
   assign do_fill    = in_update && !hit && (type_ff == lkv_pkg::REQ_PUT) && !full;
   assign do_shift   = in_update && (hit || (type_ff == lkv_pkg::REQ_PUT));
   // On eviction the last valid cell drops off; on a fill the chain grows by one
   assign miss_limit = {1'b0, fill_ff} + {{FW{1'b0}}, !full};

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit) begin
            shift_mask[i] = (i == 0) ? 1'b1 : !lvl[LOG][i-1];
         end else begin
            shift_mask[i] = (FW+1)'(i) < miss_limit;
         end
      end
   end

   assign head_entry.valid = 1'b1;
   assign head_entry.key   = key_ff;
   assign head_entry.value = (type_ff == lkv_pkg::REQ_PUT) ? value_ff : hit_value;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      assign ctrls[g].cmp_en   = accept;
      assign ctrls[g].shift_en = do_shift && shift_mask[g];
      assign match_vec[g]      = lkv_match[g];
      assign valid_vec[g]      = entries[g].valid;
   end

   lkv_cell u_head (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrls[0]),
      .cmp_key    (req_key),
      .left_entry (head_entry),
      .entry      (entries[0]),
      .match      (lkv_match[0])
   );

   for (genvar g = 1; g < ENTRIES; g++) begin : g_chain
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrls[g]),
         .cmp_key    (req_key),
         .left_entry (entries[g-1]),
         .entry      (entries[g]),
         .match      (lkv_match[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      cap_in       = cap_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rsp_evict_in = rsp_evict_ff;
      if (csr_valid) begin
         cap_in = csr_capacity;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               type_in  = req_type;
               key_in   = req_key;
               value_in = req_value;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit;
            rsp_value_in = (hit && (type_ff == lkv_pkg::REQ_GET)) ? hit_value : '0;
            rsp_evict_in = do_evict;
            if (do_fill) begin
               fill_in = fill_ff + FW'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cap_ff       <= lkv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff      <= type_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign busy           = in_update;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evict_ff;

`ifndef SYNTHESIS
   // keys are unique among valid cells, so at most one cell matches
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      in_update |-> $onehot0(match_vec))
      else $error("more than one cell matched the key");

   a_fill_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("fill count differs from number of valid cells");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= ENTRIES)
      else $error("fill count above entry count");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_update))
      else $error("result strobe without an update cycle");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");
`endif

endmodule
